// ===== src/dssf_pkg.sv =====
// dssf_pkg: shared constants, types and result layout of the dust sensor sample filter
`timescale 1ns / 1ps

package dssf_pkg;

  // filter geometry
  localparam int unsigned WINDOW_LENGTH = 10;
  localparam int unsigned GROUP_LENGTH  = 5;
  localparam int unsigned SAMPLE_BITS   = 12;

  // derived widths
  localparam int unsigned MEAN_BITS      = SAMPLE_BITS;
  localparam int unsigned GROUP_CNT_BITS = (GROUP_LENGTH > 1) ? $clog2(GROUP_LENGTH) : 1;
  localparam int unsigned GROUP_ACC_BITS = SAMPLE_BITS + $clog2(GROUP_LENGTH + 1);
  localparam int unsigned WIN_SUM_BITS   = MEAN_BITS + $clog2(WINDOW_LENGTH + 1);
  localparam int unsigned PTR_BITS       = $clog2(WINDOW_LENGTH);

  // truncating division by constants: x / N == (x * RECIP) >> SHIFT over the value range
  localparam int unsigned RECIP_BITS    = 17;
  localparam logic [RECIP_BITS-1:0] GROUP_RECIP  = 17'd52429;
  localparam int unsigned           GROUP_SHIFT  = 18;
  localparam logic [RECIP_BITS-1:0] WINDOW_RECIP = 17'd52429;
  localparam int unsigned           WINDOW_SHIFT = 19;

  // configuration
  localparam int unsigned CFG_DATA_BITS  = 10;
  localparam int unsigned CFG_INDEX_BITS = 1;
  localparam logic [CFG_DATA_BITS-1:0] GAIN_RESET   = 10'd170;
  localparam logic [CFG_DATA_BITS-1:0] OFFSET_RESET = 10'd100;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_GAIN   = 1'b0,
    CFG_OFFSET = 1'b1
  } cfg_reg_e;

  // result transaction
  localparam int unsigned DUST_BITS      = 23;
  localparam int unsigned IN_TDATA_BITS  = 16;
  localparam int unsigned OUT_TDATA_BITS = 48;
  localparam int unsigned OUT_PAD_BITS   = OUT_TDATA_BITS - DUST_BITS - 2 * MEAN_BITS;

  typedef struct packed {
    logic [OUT_PAD_BITS-1:0]     pad;
    logic signed [DUST_BITS-1:0] dust_milli;
    logic [MEAN_BITS-1:0]        filtered;
    logic [MEAN_BITS-1:0]        group_mean;
  } result_t;

  // output buffer
  localparam int unsigned FIFO_DEPTH    = 4;
  localparam int unsigned FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
  localparam int unsigned OCC_BITS      = $clog2(FIFO_DEPTH + 1);

endpackage

// ===== src/dssf_ram.sv =====
// dssf_ram: generic single write port, single read port ram with registered read
`timescale 1ns / 1ps

module dssf_ram #(
  parameter int unsigned DATA_WIDTH = 12,
  parameter int unsigned DEPTH      = 10
) (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [$clog2(DEPTH)-1:0]      waddr_i,
  input  logic [DATA_WIDTH-1:0]         wdata_i,
  input  logic                          re_i,
  input  logic [$clog2(DEPTH)-1:0]      raddr_i,
  output logic [DATA_WIDTH-1:0]         rdata_o
);

  logic [DATA_WIDTH-1:0] mem_q [DEPTH];
  logic [DATA_WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/dust_sensor_sample_filter.sv =====
// dust_sensor_sample_filter: group mean, moving average window and dust estimate
//
// Usage:
//   s_axis carries one raw converter reading per transaction (tdata[11:0]).
//   Every fifth reading closes a group; its truncated mean enters a 10-point
//   moving average and one result transaction leaves on m_axis.
//   cfg carries register writes (index 0 gain_milli, index 1 offset_milli);
//   write only while no result is outstanding. cfg_ready_o is always high.
// Path: a closing reading's mean passes the window update, window mean and
//   dust estimate registers into the output buffer, which presents it on m_axis.
// Throughput: one reading per cycle while s_axis_tready is high. The window lives
//   in a 10-entry ram with one registered read and one write per cycle; each closing
//   reading after the first reads the oldest entry and writes the new mean back next cycle.
// Reset: group accumulator, window sum and pointers clear; the first group
//   mean after reset seeds the whole window and is also the first filtered
//   value. Gain and offset return to 170 and 100.
// Stall: a 4-entry output buffer holds results; s_axis_tready drops only on a
//   group-closing reading when the buffer plus the results in flight are full.
`timescale 1ns / 1ps

module dust_sensor_sample_filter (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  // input stream, tdata: sample[11:0], zero pad[15:12]
  input  logic                                    s_axis_tvalid,
  output logic                                    s_axis_tready,
  input  logic [dssf_pkg::IN_TDATA_BITS-1:0]      s_axis_tdata,
  // result stream, tdata: group_mean[11:0], filtered[23:12], dust_milli[46:24], pad[47]
  output logic                                    m_axis_tvalid,
  input  logic                                    m_axis_tready,
  output logic [dssf_pkg::OUT_TDATA_BITS-1:0]     m_axis_tdata,
  // configuration write channel
  input  logic                                    cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  logic [dssf_pkg::CFG_INDEX_BITS-1:0]     cfg_index_i,
  input  logic [dssf_pkg::CFG_DATA_BITS-1:0]      cfg_data_i
);

  localparam int unsigned MB  = dssf_pkg::MEAN_BITS;
  localparam int unsigned AB  = dssf_pkg::GROUP_ACC_BITS;
  localparam int unsigned SB  = dssf_pkg::WIN_SUM_BITS;
  localparam int unsigned PB  = dssf_pkg::PTR_BITS;
  localparam int unsigned CB  = dssf_pkg::GROUP_CNT_BITS;
  localparam int unsigned RB  = dssf_pkg::RECIP_BITS;
  localparam int unsigned GB  = dssf_pkg::CFG_DATA_BITS;
  localparam int unsigned DB  = dssf_pkg::DUST_BITS;
  localparam int unsigned FPB = dssf_pkg::FIFO_PTR_BITS;
  localparam int unsigned OB  = dssf_pkg::OCC_BITS;

  // ---------------- configuration ----------------
  logic [GB-1:0] gain_q, offset_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q   <= dssf_pkg::GAIN_RESET;
      offset_q <= dssf_pkg::OFFSET_RESET;
    end else if (cfg_valid_i) begin
      unique case (dssf_pkg::cfg_reg_e'(cfg_index_i))
        dssf_pkg::CFG_GAIN:   gain_q   <= cfg_data_i;
        dssf_pkg::CFG_OFFSET: offset_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------- stage 0: group accumulation ----------------
  logic [AB-1:0]    group_acc_q, group_acc_d;
  logic [CB-1:0]    group_count_q, group_count_d;
  logic             primed_q, primed_d;
  logic             wrapped_q, wrapped_d;
  logic [PB-1:0]    oldest_ptr_q, oldest_ptr_d;
  logic [OB-1:0]    occ_q, occ_d;

  logic             s_accept, m_accept, last_in_group, complete;
  logic [AB-1:0]    acc_sum;
  logic [AB+RB-1:0] mean_prod;
  logic [MB-1:0]    mean0;
  logic             ram_re;

  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign m_accept      = m_axis_tvalid && m_axis_tready;
  assign last_in_group = (group_count_q == CB'(dssf_pkg::GROUP_LENGTH - 1));
  assign complete      = s_accept && last_in_group;
  assign s_axis_tready = !last_in_group || (occ_q < OB'(dssf_pkg::FIFO_DEPTH));

  assign acc_sum   = group_acc_q + AB'(s_axis_tdata[dssf_pkg::SAMPLE_BITS-1:0]);
  assign mean_prod = (AB+RB)'(acc_sum) * (AB+RB)'(dssf_pkg::GROUP_RECIP);
  assign mean0     = mean_prod[dssf_pkg::GROUP_SHIFT +: MB];
  assign ram_re    = complete && primed_q;

  always_comb begin
    group_acc_d   = group_acc_q;
    group_count_d = group_count_q;
    primed_d      = primed_q;
    wrapped_d     = wrapped_q;
    oldest_ptr_d  = oldest_ptr_q;
    if (s_accept) begin
      if (last_in_group) begin
        group_acc_d   = '0;
        group_count_d = '0;
      end else begin
        group_acc_d   = acc_sum;
        group_count_d = group_count_q + CB'(1);
      end
    end
    if (complete) begin
      if (!primed_q) begin
        primed_d = 1'b1;
      end else if (oldest_ptr_q == PB'(dssf_pkg::WINDOW_LENGTH - 1)) begin
        oldest_ptr_d = '0;
        wrapped_d    = 1'b1;
      end else begin
        oldest_ptr_d = oldest_ptr_q + PB'(1);
      end
    end
    occ_d = occ_q + OB'(complete) - OB'(m_accept);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      group_acc_q   <= '0;
      group_count_q <= '0;
      primed_q      <= 1'b0;
      wrapped_q     <= 1'b0;
      oldest_ptr_q  <= '0;
      occ_q         <= '0;
    end else begin
      group_acc_q   <= group_acc_d;
      group_count_q <= group_count_d;
      primed_q      <= primed_d;
      wrapped_q     <= wrapped_d;
      oldest_ptr_q  <= oldest_ptr_d;
      occ_q         <= occ_d;
    end
  end

  // ---------------- stage 1: window update ----------------
  logic          s1_valid_q, s1_prime_q, s1_wrapped_q;
  logic [PB-1:0] s1_addr_q;
  logic [MB-1:0] s1_mean_q;
  logic [MB-1:0] prime_mean_q, ram_rdata, old_mean;
  logic [SB-1:0] window_sum_q, window_sum_d;
  logic          ram_we;

  dssf_ram #(
    .DATA_WIDTH(MB),
    .DEPTH     (dssf_pkg::WINDOW_LENGTH)
  ) u_window_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(s1_addr_q),
    .wdata_i(s1_mean_q),
    .re_i   (ram_re),
    .raddr_i(oldest_ptr_q),
    .rdata_o(ram_rdata)
  );

  // entries not yet overwritten since priming still hold the seed mean
  assign old_mean = s1_wrapped_q ? ram_rdata : prime_mean_q;
  assign ram_we   = s1_valid_q && !s1_prime_q;

  always_comb begin
    window_sum_d = window_sum_q;
    if (s1_valid_q) begin
      if (s1_prime_q) begin
        window_sum_d = SB'(s1_mean_q) * SB'(dssf_pkg::WINDOW_LENGTH);
      end else begin
        window_sum_d = window_sum_q - SB'(old_mean) + SB'(s1_mean_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q   <= 1'b0;
      window_sum_q <= '0;
    end else begin
      s1_valid_q   <= complete;
      window_sum_q <= window_sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (complete) begin
      s1_prime_q   <= !primed_q;
      s1_wrapped_q <= wrapped_q;
      s1_addr_q    <= oldest_ptr_q;
      s1_mean_q    <= mean0;
    end
    if (s1_valid_q && s1_prime_q) begin
      prime_mean_q <= s1_mean_q;
    end
  end

  // ---------------- stage 2: window mean ----------------
  logic             s2_valid_q, s2_prime_q;
  logic [MB-1:0]    s2_mean_q;
  logic [SB+RB-1:0] filt_prod;
  logic [MB-1:0]    filt2;

  assign filt_prod = (SB+RB)'(window_sum_q) * (SB+RB)'(dssf_pkg::WINDOW_RECIP);
  assign filt2     = s2_prime_q ? s2_mean_q : filt_prod[dssf_pkg::WINDOW_SHIFT +: MB];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      s2_prime_q <= s1_prime_q;
      s2_mean_q  <= s1_mean_q;
    end
  end

  // ---------------- stage 3: dust estimate ----------------
  logic                 s3_valid_q;
  logic [MB-1:0]        s3_mean_q, s3_filt_q;
  logic [GB+MB-1:0]     dust_prod;
  logic signed [DB-1:0] dust;
  dssf_pkg::result_t    result;

  assign dust_prod = (GB+MB)'(gain_q) * (GB+MB)'(s3_filt_q);
  assign dust      = $signed(DB'(dust_prod)) - $signed(DB'(offset_q));

  always_comb begin
    result            = '0;
    result.group_mean = s3_mean_q;
    result.filtered   = s3_filt_q;
    result.dust_milli = dust;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else begin
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_valid_q) begin
      s3_mean_q <= s2_mean_q;
      s3_filt_q <= filt2;
    end
  end

  // ---------------- output buffer ----------------
  dssf_pkg::result_t fifo_q [dssf_pkg::FIFO_DEPTH];
  logic [FPB-1:0]    wr_ptr_q, rd_ptr_q;
  logic [OB-1:0]     fifo_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q   <= '0;
      rd_ptr_q   <= '0;
      fifo_cnt_q <= '0;
    end else begin
      if (s3_valid_q) begin
        wr_ptr_q <= wr_ptr_q + FPB'(1);
      end
      if (m_accept) begin
        rd_ptr_q <= rd_ptr_q + FPB'(1);
      end
      fifo_cnt_q <= fifo_cnt_q + OB'(s3_valid_q) - OB'(m_accept);
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_valid_q) begin
      fifo_q[wr_ptr_q] <= result;
    end
  end

  assign m_axis_tvalid = (fifo_cnt_q != '0);
  assign m_axis_tdata  = fifo_q[rd_ptr_q];

endmodule

// ===== src/dssf_checker.sv =====
// dssf_checker: port-level assertions for the dust sensor sample filter, bound to the top level
`timescale 1ns / 1ps

module dssf_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                s_axis_tvalid,
  input logic                                s_axis_tready,
  input logic                                m_axis_tvalid,
  input logic                                m_axis_tready,
  input logic [dssf_pkg::OUT_TDATA_BITS-1:0] m_axis_tdata
);

  localparam int unsigned CB = dssf_pkg::GROUP_CNT_BITS;

  dssf_pkg::result_t res;
  logic              seen_q;
  logic [CB-1:0]     in_cnt_q;

  assign res = m_axis_tdata;

  // marks that the first result after reset has been taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= 1'b0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      seen_q <= 1'b1;
    end
  end

  // readings taken since reset, held once a full group went in
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_cnt_q <= '0;
    end else if (s_axis_tvalid && s_axis_tready &&
                 in_cnt_q != CB'(dssf_pkg::GROUP_LENGTH)) begin
      in_cnt_q <= in_cnt_q + CB'(1);
    end
  end

  // a stalled result stays and holds its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // first result after reset: the seeded window gives filtered equal to the group mean
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !seen_q |-> res.filtered == res.group_mean)
    else $error("first filtered value differs from first group mean");

  // the estimate never falls below minus the size of the offset range (-1024)
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && res.dust_milli[dssf_pkg::DUST_BITS-1]
      |-> &res.dust_milli[dssf_pkg::DUST_BITS-1:dssf_pkg::CFG_DATA_BITS])
    else $error("dust estimate below offset range");

  // no result can appear before at least one group of readings went in
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> in_cnt_q == CB'(dssf_pkg::GROUP_LENGTH))
    else $error("result before a full group of readings");

  // the padding bit of the result is zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> res.pad == '0)
    else $error("result padding not zero");

endmodule

bind dust_sensor_sample_filter dssf_checker u_dssf_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);

// ===== tb/dust_sensor_sample_filter_tb.sv =====
// dust_sensor_sample_filter_tb: self-checking stream testbench for the dust sensor sample filter
`timescale 1ns / 1ps

module dust_sensor_sample_filter_tb;

  localparam int unsigned RAND_ITEMS    = 1600;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned NROWS         = 21;

  localparam int unsigned MB   = dssf_pkg::MEAN_BITS;
  localparam int unsigned DB   = dssf_pkg::DUST_BITS;
  localparam int unsigned GB   = dssf_pkg::CFG_DATA_BITS;
  localparam int unsigned AB   = dssf_pkg::GROUP_ACC_BITS;
  localparam int unsigned SB   = dssf_pkg::WIN_SUM_BITS;
  localparam int unsigned INB  = dssf_pkg::IN_TDATA_BITS;
  localparam int unsigned OUTB = dssf_pkg::OUT_TDATA_BITS;
  localparam int unsigned IXB  = dssf_pkg::CFG_INDEX_BITS;

  typedef enum logic [0:0] {
    ROW_SAMPLE,
    ROW_WRITE
  } row_kind_e;

  // value holds the reading or the register data; mean/filt/dust are typed only when pinned
  typedef struct packed {
    row_kind_e            kind;
    dssf_pkg::cfg_reg_e   idx;
    logic [11:0]          value;
    logic                 pinned;
    logic [MB-1:0]        mean;
    logic [MB-1:0]        filt;
    logic signed [DB-1:0] dust;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  logic            s_axis_tvalid;
  logic            s_axis_tready;
  logic [INB-1:0]  s_axis_tdata;   // sample[11:0], zero pad[15:12]
  logic            m_axis_tvalid;
  logic            m_axis_tready;
  logic [OUTB-1:0] m_axis_tdata;   // group_mean[11:0], filtered[23:12], dust_milli[46:24]
  logic            cfg_valid_i;
  logic            cfg_ready_o;
  logic [IXB-1:0]  cfg_index_i;
  logic [GB-1:0]   cfg_data_i;

  dust_sensor_sample_filter dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  // predictor state
  logic [AB-1:0] grp_sum = '0;
  int unsigned   grp_cnt = 0;
  logic [MB-1:0] win_means [dssf_pkg::WINDOW_LENGTH];
  logic [SB-1:0] win_sum = '0;
  int unsigned   oldest_slot = 0;
  bit            win_full = 1'b0;
  logic [GB-1:0] gain_q = dssf_pkg::GAIN_RESET;
  logic [GB-1:0] offset_q = dssf_pkg::OFFSET_RESET;

  dssf_pkg::result_t pending_results [$];
  int unsigned       errors = 0;
  int unsigned       results_seen = 0;
  int unsigned       readings_sent = 0;
  int unsigned       cycle_count = 0;
  int unsigned       tx_idle = 0;
  int unsigned       rx_idle = 0;
  dssf_pkg::result_t seen_r, want_r;

  stim_row_t dir_rows [NROWS] = '{
    '{ROW_WRITE,  dssf_pkg::CFG_GAIN,   12'd1023, 1'b0, 12'd0,    12'd0,    23'sd0},
    '{ROW_WRITE,  dssf_pkg::CFG_OFFSET, 12'd0,    1'b0, 12'd0,    12'd0,    23'sd0},
    '{ROW_SAMPLE, dssf_pkg::CFG_GAIN,   12'hFFF,  1'b0, 12'd0,    12'd0,    23'sd0},
    '{ROW_SAMPLE, dssf_pkg::CFG_GAIN,   12'hFFF,  1'b0, 12'd0,    12'd0,    23'sd0},
    '{ROW_SAMPLE, dssf_pkg::CFG_GAIN,   12'hFFF,  1'b0, 12'd0,    12'd0,    23'sd0},
    '{ROW_SAMPLE, dssf_pkg::CFG_GAIN,   12'hFFF,  1'b0, 12'd0,    12'd0,    23'sd0},
    // first group seeds the window: largest estimate possible
    '{ROW_SAMPLE, dssf_pkg::CFG_GAIN,   12'hFFF,  1'b1, 12'd4095, 12'd4095, 23'sd4189185},
    '{ROW_WRITE,  dssf_pkg::CFG_GAIN,   12'd0,    1'b0, 12'd0,    12'd0,    23'sd0},
    '{ROW_WRITE,  dssf_pkg::CFG_OFFSET, 12'd1023, 1'b0, 12'd0,    12'd0,    23'sd0},
    '{ROW_SAMPLE, dssf_pkg::CFG_GAIN,   12'h000,  1'b0, 12'd0,    12'd0,    23'sd0},
    '{ROW_SAMPLE, dssf_pkg::CFG_GAIN,   12'h000,  1'b0, 12'd0,    12'd0,    23'sd0},
    '{ROW_SAMPLE, dssf_pkg::CFG_GAIN,   12'h000,  1'b0, 12'd0,    12'd0,    23'sd0},
    '{ROW_SAMPLE, dssf_pkg::CFG_GAIN,   12'h000,  1'b0, 12'd0,    12'd0,    23'sd0},
    // zero gain gives the most negative estimate
    '{ROW_SAMPLE, dssf_pkg::CFG_GAIN,   12'h000,  1'b1, 12'd0,    12'd3685, -23'sd1023},
    '{ROW_WRITE,  dssf_pkg::CFG_GAIN,   12'd170,  1'b0, 12'd0,    12'd0,    23'sd0},
    '{ROW_WRITE,  dssf_pkg::CFG_OFFSET, 12'd100,  1'b0, 12'd0,    12'd0,    23'sd0},
    '{ROW_SAMPLE, dssf_pkg::CFG_GAIN,   12'hAAA,  1'b0, 12'd0,    12'd0,    23'sd0},
    '{ROW_SAMPLE, dssf_pkg::CFG_GAIN,   12'h555,  1'b0, 12'd0,    12'd0,    23'sd0},
    '{ROW_SAMPLE, dssf_pkg::CFG_GAIN,   12'hFFF,  1'b0, 12'd0,    12'd0,    23'sd0},
    '{ROW_SAMPLE, dssf_pkg::CFG_GAIN,   12'h000,  1'b0, 12'd0,    12'd0,    23'sd0},
    '{ROW_SAMPLE, dssf_pkg::CFG_GAIN,   12'h001,  1'b0, 12'd0,    12'd0,    23'sd0}
  };

  // accumulate one reading; on a closing reading update the window and build the result
  function automatic bit filter_reading(input logic [11:0] s, output dssf_pkg::result_t r);
    logic [MB-1:0] mean;
    logic [MB-1:0] filt;
    int            d;
    r = '0;
    grp_sum = grp_sum + AB'(s);
    grp_cnt++;
    if (grp_cnt < dssf_pkg::GROUP_LENGTH) return 1'b0;
    mean = MB'(grp_sum / dssf_pkg::GROUP_LENGTH);
    grp_sum = '0;
    grp_cnt = 0;
    if (!win_full) begin
      // first mean after reset fills every slot
      win_full = 1'b1;
      foreach (win_means[i]) win_means[i] = mean;
      win_sum = SB'(mean * dssf_pkg::WINDOW_LENGTH);
      oldest_slot = 0;
      filt = mean;
    end else begin
      win_sum = win_sum - win_means[oldest_slot] + SB'(mean);
      win_means[oldest_slot] = mean;
      oldest_slot = (oldest_slot + 1 >= dssf_pkg::WINDOW_LENGTH) ? 0 : oldest_slot + 1;
      filt = MB'(win_sum / dssf_pkg::WINDOW_LENGTH);
    end
    d = int'(gain_q) * int'(filt) - int'(offset_q);
    r.group_mean = mean;
    r.filtered   = filt;
    r.dust_milli = d[DB-1:0];
    return 1'b1;
  endfunction

  function automatic logic [11:0] rand_reading();
    case ($urandom_range(7))
      0: return 12'h000;
      1: return 12'hFFF;
      2: return 12'($urandom_range(15));
      default: return 12'($urandom);
    endcase
  endfunction

  // valid stays high after the transaction; the next call or settle() decides at the next negedge
  task automatic send_reading(input logic [11:0] s, input bit pin,
                              input dssf_pkg::result_t pinned_r);
    dssf_pkg::result_t r;
    bit                closes;
    @(negedge clk_i);
    while ($urandom_range(99) < tx_idle) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(INB - 12){1'b0}}, s};
    do @(posedge clk_i); while (!s_axis_tready);
    readings_sent++;
    closes = filter_reading(s, r);
    if (pin) pending_results.push_back(pinned_r);
    else if (closes) pending_results.push_back(r);
  endtask

  task automatic write_reg(input dssf_pkg::cfg_reg_e idx, input logic [GB-1:0] v);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      dssf_pkg::CFG_GAIN:   gain_q   = v;
      dssf_pkg::CFG_OFFSET: offset_q = v;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // stop sending and let every outstanding result drain out of the pipeline
  task automatic settle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  always @(negedge clk_i) begin
    m_axis_tready <= rst_ni && ($urandom_range(99) >= rx_idle);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      seen_r = m_axis_tdata;
      results_seen++;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: mean %0d filtered %0d dust %0d", $time,
                 seen_r.group_mean, seen_r.filtered, seen_r.dust_milli);
      end else begin
        want_r = pending_results.pop_front();
        if (seen_r.group_mean !== want_r.group_mean) begin
          errors++;
          $display("%0t: group_mean expected %0d got %0d", $time,
                   want_r.group_mean, seen_r.group_mean);
        end
        if (seen_r.filtered !== want_r.filtered) begin
          errors++;
          $display("%0t: filtered expected %0d got %0d", $time,
                   want_r.filtered, seen_r.filtered);
        end
        if (seen_r.dust_milli !== want_r.dust_milli) begin
          errors++;
          $display("%0t: dust_milli expected %0d got %0d", $time,
                   want_r.dust_milli, seen_r.dust_milli);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d results outstanding", $time,
               cycle_count, pending_results.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    dssf_pkg::result_t pin_r;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = dssf_pkg::CFG_GAIN;
    cfg_data_i    = '0;
    tx_idle = 35;
    rx_idle = 73;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed table
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_WRITE) begin
        settle();
        write_reg(dir_rows[i].idx, GB'(dir_rows[i].value));
      end else begin
        pin_r = '0;
        pin_r.group_mean = dir_rows[i].mean;
        pin_r.filtered   = dir_rows[i].filt;
        pin_r.dust_milli = dir_rows[i].dust;
        send_reading(dir_rows[i].value, dir_rows[i].pinned, pin_r);
      end
    end

    // random phases: receiver-heavy idling, sender-heavy idling, then full rate
    for (int ph = 0; ph < 3; ph++) begin
      tx_idle = (ph == 0) ? 35 : (ph == 1) ? 73 : 0;
      rx_idle = (ph == 0) ? 73 : (ph == 1) ? 35 : 0;
      settle();
      if (ph == 1) begin
        write_reg(dssf_pkg::CFG_GAIN, 10'd1023);
        write_reg(dssf_pkg::CFG_OFFSET, 10'd1023);
      end else begin
        write_reg(dssf_pkg::CFG_GAIN, GB'($urandom));
        write_reg(dssf_pkg::CFG_OFFSET, GB'($urandom));
      end
      repeat (RAND_ITEMS / 3) send_reading(rand_reading(), 1'b0, '0);
    end

    settle();
    $display("covered %0d readings and %0d filter results over three idling phases",
             readings_sent, results_seen);
    $display("gain and offset swept through both extremes, %0d mismatches", errors);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
